@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the identifier allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of CLK, disabled while RSTN is low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Check that a condition never holds out of reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

@@ rtl/eida_pkg.sv @@
// ----------------------------------------------------------------------------
// eida_pkg
// Shared constants, codes, types and helpers for the identifier allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eida_pkg;

    // Pool geometry
    localparam int unsigned POOL_SIZE  = 64;
    localparam int unsigned ID_W       = $clog2(POOL_SIZE);
    localparam int unsigned CNT_W      = ID_W + 1;

    // Bitmap scan geometry: one word of the alive map per cycle
    localparam int unsigned SCAN_W     = 8;
    localparam int unsigned SCAN_WORDS = POOL_SIZE / SCAN_W;
    localparam int unsigned WPTR_W     = $clog2(SCAN_WORDS);
    localparam int unsigned SUB_W      = $clog2(SCAN_W);

    // Field widths
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned STATUS_W   = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic            start;
        logic [ID_W-1:0] start_index;
    } scan_cmd_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] next_index;
    } scan_rsp_t;

    // Position of the lowest set bit of a scan word (word assumed nonzero)
    function automatic logic [SUB_W-1:0] lowest_set(input logic [SCAN_W-1:0] w);
        logic [SUB_W-1:0] pos;
        pos = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = SUB_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/eida_if.sv @@
// ----------------------------------------------------------------------------
// eida_if
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface eida_req_if;
    import eida_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     index_in;

    modport source (output valid, output req_type, output index_in, input ready);
    modport sink   (input valid, input req_type, input index_in, output ready);
endinterface

interface eida_rsp_if;
    import eida_pkg::*;

    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    index_out;
    logic                is_alive;
    logic [CNT_W-1:0]    live_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output index_out, output is_alive,
                    output live_count, output status, input ready);
    modport sink   (input valid, input index_out, input is_alive,
                    input live_count, input status, output ready);
endinterface

@@ rtl/eida_ram.sv @@
// ----------------------------------------------------------------------------
// eida_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eida_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/eida_scan.sv @@
// ----------------------------------------------------------------------------
// eida_scan
// Iterative next-live search over the alive bitmap, one word per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eida_scan (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [eida_pkg::POOL_SIZE-1:0]   alive,
    input  eida_pkg::scan_cmd_t              cmd,
    output eida_pkg::scan_rsp_t              rsp
);
    import eida_pkg::*;

    logic              busy_reg, busy_next;
    logic [WPTR_W-1:0] ptr_reg, ptr_next;
    logic [SCAN_W-1:0] mask_reg, mask_next;
    logic [SCAN_W-1:0] word;
    logic              hit;
    logic              last;

    // Masked bitmap word under the pointer
    assign word = alive[{ptr_reg, SUB_W'(0)} +: SCAN_W] & mask_reg;
    assign hit  = |word;
    assign last = (ptr_reg == WPTR_W'(SCAN_WORDS - 1));

    always_comb
    begin
        busy_next      = busy_reg;
        ptr_next       = ptr_reg;
        mask_next      = mask_reg;
        rsp.done       = 1'b0;
        rsp.next_index = CNT_W'(POOL_SIZE);
        if (cmd.start)
        begin
            // Load the first word; drop bits below the start index
            busy_next = 1'b1;
            ptr_next  = cmd.start_index[ID_W-1:SUB_W];
            mask_next = {SCAN_W{1'b1}} << cmd.start_index[SUB_W-1:0];
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                rsp.done       = 1'b1;
                rsp.next_index = {1'b0, ptr_reg, lowest_set(word)};
                busy_next      = 1'b0;
            end
            else if (last)
            begin
                rsp.done  = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                // Advance to the next word, all bits eligible
                ptr_next  = ptr_reg + WPTR_W'(1);
                mask_next = {SCAN_W{1'b1}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        mask_reg <= mask_next;
    end

endmodule

@@ rtl/entity_id_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// entity_id_allocator_unit
// Identifier pool with a LIFO free stack, alive bitmap and next-live query.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake    Payload
//  -------  ---  -----------  ------------------------------------------------
//  req      in   valid/ready  req_type, index_in
//  rsp      out  valid/ready  index_out, is_alive, live_count, status
//
//  Allocate, free and unused codes pass the accept, execute and result
//  states; the result register loads from the result state. Query adds a
//  scan state after execute, where the scan unit checks one 8-bit word of
//  the alive map per cycle until a live bit turns up or the last word is checked.
//  One request is in flight at a time; req.ready is high only when idle.
//  A new request is taken while a result still sits in the output register;
//  its own result holds in the result state until that register drains.
//  Reset clears the alive map, the counters and control; the stack RAM is
//  not cleared, as only entries below the stack depth are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module entity_id_allocator_unit (
    input  logic       clk,
    input  logic       rst_n,
    eida_req_if.sink   req,
    eida_rsp_if.source rsp
);
    import eida_pkg::*;

    // Control state
    state_t                 state_reg, state_next;
    logic [REQ_W-1:0]       req_type_reg, req_type_next;
    logic [ID_W-1:0]        idx_reg, idx_next;

    // Pool state
    logic [POOL_SIZE-1:0]   alive_reg, alive_next;
    logic [CNT_W-1:0]       depth_reg, depth_next;
    logic [CNT_W-1:0]       total_reg, total_next;

    // Staged result, waits here for the output register
    logic [CNT_W-1:0]       res_index_reg, res_index_next;
    logic                   res_alive_reg, res_alive_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]       index_out_reg, index_out_next;
    logic                   is_alive_reg, is_alive_next;
    logic [CNT_W-1:0]       live_count_reg, live_count_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    // Stack RAM port
    logic                   ram_we;
    logic [ID_W-1:0]        ram_waddr;
    logic [ID_W-1:0]        ram_wdata;
    logic [ID_W-1:0]        ram_raddr;
    logic [ID_W-1:0]        ram_rdata;
    logic [CNT_W-1:0]       depth_m1;

    // Scan unit
    scan_cmd_t              scan_cmd;
    scan_rsp_t              scan_rsp;

    logic [ID_W-1:0]        alloc_id;

    // Keep the top of stack on the read port; its registered read data is
    // valid by the execute state, where allocate uses it.
    assign depth_m1  = depth_reg - CNT_W'(1);
    assign ram_raddr = depth_m1[ID_W-1:0];

    // Pop from the stack when it holds entries, else take the live count
    assign alloc_id = (depth_reg != '0) ? ram_rdata : total_reg[ID_W-1:0];

    eida_ram #(
        .WIDTH (ID_W),
        .DEPTH (POOL_SIZE)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    eida_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .alive (alive_reg),
        .cmd   (scan_cmd),
        .rsp   (scan_rsp)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.index_out  = index_out_reg;
    assign rsp.is_alive   = is_alive_reg;
    assign rsp.live_count = live_count_reg;
    assign rsp.status     = status_reg;

    always_comb
    begin
        state_next           = state_reg;
        req_type_next        = req_type_reg;
        idx_next             = idx_reg;
        alive_next           = alive_reg;
        depth_next           = depth_reg;
        total_next           = total_reg;
        res_index_next       = res_index_reg;
        res_alive_next       = res_alive_reg;
        res_status_next      = res_status_reg;
        out_valid_next       = out_valid_reg;
        index_out_next       = index_out_reg;
        is_alive_next        = is_alive_reg;
        live_count_next      = live_count_reg;
        status_next          = status_reg;
        ram_we               = 1'b0;
        ram_waddr            = depth_reg[ID_W-1:0];
        ram_wdata            = idx_reg;
        scan_cmd.start       = 1'b0;
        scan_cmd.start_index = idx_reg;

        // Drop the output once its transfer completes
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next = req.req_type;
                    idx_next      = req.index_in;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_index_next  = '0;
                res_alive_next  = 1'b0;
                res_status_next = ST_OK;
                state_next      = S_RESULT;
                case (req_type_reg)
                    REQ_ALLOC:
                    begin
                        if (total_reg >= CNT_W'(POOL_SIZE))
                        begin
                            // Pool full: change nothing
                            res_index_next  = CNT_W'(POOL_SIZE);
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            if (depth_reg != '0)
                            begin
                                depth_next = depth_m1;
                            end
                            alive_next[alloc_id] = 1'b1;
                            total_next           = total_reg + CNT_W'(1);
                            res_index_next       = {1'b0, alloc_id};
                        end
                    end

                    REQ_FREE:
                    begin
                        if (!alive_reg[idx_reg])
                        begin
                            // Free of a dead identifier: change nothing
                            res_status_next = ST_DEAD;
                        end
                        else
                        begin
                            alive_next[idx_reg] = 1'b0;
                            if (depth_reg < CNT_W'(POOL_SIZE))
                            begin
                                ram_we     = 1'b1;
                                depth_next = depth_reg + CNT_W'(1);
                            end
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - CNT_W'(1);
                            end
                        end
                    end

                    REQ_QUERY:
                    begin
                        res_alive_next = alive_reg[idx_reg];
                        scan_cmd.start = 1'b1;
                        state_next     = S_SCAN;
                    end

                    default:
                    begin
                        // Unused code: zero result, current live count
                        res_index_next = '0;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    res_index_next = scan_rsp.next_index;
                    state_next     = S_RESULT;
                end
            end

            S_RESULT:
            begin
                // Hold until the output register is free or draining
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    index_out_next  = res_index_reg;
                    is_alive_next   = res_alive_reg;
                    live_count_next = total_reg;
                    status_next     = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alive_reg     <= '0;
            depth_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alive_reg     <= alive_next;
            depth_reg     <= depth_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        idx_reg        <= idx_next;
        res_index_reg  <= res_index_next;
        res_alive_reg  <= res_alive_next;
        res_status_reg <= res_status_next;
        index_out_reg  <= index_out_next;
        is_alive_reg   <= is_alive_next;
        live_count_reg <= live_count_next;
        status_reg     <= status_next;
    end

    // The live count always matches the population of the alive map
    `ASSERT_CLK(a_count_matches_map, clk, rst_n,
        $countones(alive_reg) == int'(total_reg),
        "live count differs from alive map population")

    // Stack entries are dead identifiers, so stack plus live stay in the pool
    `ASSERT_NEVER(a_stack_overflow, clk, rst_n,
        (int'(depth_reg) + int'(total_reg)) > int'(POOL_SIZE),
        "free stack depth plus live count exceeds pool size")

    // An allocate that succeeds must hand out an identifier that was dead
    `ASSERT_NEVER(a_alloc_live_id, clk, rst_n,
        (state_reg == S_EXEC) && (req_type_reg == REQ_ALLOC)
            && (total_reg < CNT_W'(POOL_SIZE)) && alive_reg[alloc_id],
        "allocate handed out a live identifier")

endmodule

@@ sim/entity_id_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// entity_id_allocator_unit_tb
// Self-checking bench for the identifier pool: a shadow pool in a small
// scoreboard class predicts every response from the accepted requests, and
// the live responses are checked field by field, in order, against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entity_id_allocator_unit_tb;
    import eida_pkg::*;

    // The request code that the block leaves unused: it must change nothing
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int unsigned ITEM_TARGET  = 550;
    localparam int unsigned CALM_ITEMS   = 60;   // tail of the run with no idling
    localparam int unsigned PAUSE_AT     = 300;  // hold the sender until drained here
    localparam int unsigned SETTLE_EDGES = 24;   // edges to watch for stray responses at the end

    // ------------------------------------------------------------------------
    // Shadow pool: alive bits, LIFO of freed ids and the live count, plus the
    // queue of responses that the accepted requests still owe.
    // ------------------------------------------------------------------------
    class id_pool_tracker;
        logic [POOL_SIZE-1:0] alive_bits;
        logic [ID_W-1:0]      freed_ids[POOL_SIZE];
        int unsigned          freed_depth;
        int unsigned          live_total;
        int unsigned          error_count;
        logic [CNT_W-1:0]     owed_index[$];
        logic                 owed_alive[$];
        logic [CNT_W-1:0]     owed_count[$];
        logic [STATUS_W-1:0]  owed_status[$];

        function new();
            alive_bits  = '0;
            freed_depth = 0;
            live_total  = 0;
            error_count = 0;
        endfunction

        task report(input string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            error_count++;
        endtask

        // Update the shadow pool for one accepted request and queue its response
        function void take_request(input logic [REQ_W-1:0] op, input logic [ID_W-1:0] idx);
            logic [CNT_W-1:0]    index_out;
            logic                is_alive;
            logic [STATUS_W-1:0] status;
            int unsigned         id;
            index_out = '0;
            is_alive  = 1'b0;
            status    = ST_OK;
            case (op)
                REQ_ALLOC:
                begin
                    if (live_total >= POOL_SIZE)
                    begin
                        index_out = CNT_W'(POOL_SIZE);
                        status    = ST_FULL;
                    end
                    else
                    begin
                        // Reuse the most recently freed id, else the live count
                        if (freed_depth > 0)
                        begin
                            freed_depth--;
                            id = freed_ids[freed_depth];
                        end
                        else
                        begin
                            id = live_total;
                        end
                        alive_bits[id] = 1'b1;
                        live_total++;
                        index_out = CNT_W'(id);
                    end
                end
                REQ_FREE:
                begin
                    if (!alive_bits[idx])
                    begin
                        status = ST_DEAD;
                    end
                    else
                    begin
                        alive_bits[idx]        = 1'b0;
                        freed_ids[freed_depth] = idx;
                        freed_depth++;
                        live_total--;
                    end
                end
                REQ_QUERY:
                begin
                    is_alive  = alive_bits[idx];
                    index_out = CNT_W'(POOL_SIZE);
                    // Walk down so that the lowest live index at or above idx wins
                    for (int i = POOL_SIZE - 1; i >= int'(idx); i--)
                    begin
                        if (alive_bits[i])
                        begin
                            index_out = CNT_W'(i);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            owed_index.push_back(index_out);
            owed_alive.push_back(is_alive);
            owed_count.push_back(CNT_W'(live_total));
            owed_status.push_back(status);
        endfunction

        function int unsigned pending();
            return owed_index.size();
        endfunction

        // A random live id, or any id when the pool is empty
        function logic [ID_W-1:0] pick_live();
            logic [ID_W-1:0] ids[$];
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                if (alive_bits[i])
                begin
                    ids.push_back(ID_W'(i));
                end
            end
            if (ids.size() == 0)
            begin
                return ID_W'($urandom);
            end
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction

        task check_result(input logic [CNT_W-1:0] index_out, input logic is_alive,
                          input logic [CNT_W-1:0] live_count,
                          input logic [STATUS_W-1:0] status);
            logic [CNT_W-1:0]    want_index;
            logic                want_alive;
            logic [CNT_W-1:0]    want_count;
            logic [STATUS_W-1:0] want_status;
            if (owed_index.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            want_index  = owed_index.pop_front();
            want_alive  = owed_alive.pop_front();
            want_count  = owed_count.pop_front();
            want_status = owed_status.pop_front();
            if (index_out !== want_index)
            begin
                report($sformatf("index_out %0d, want %0d", index_out, want_index));
            end
            if (is_alive !== want_alive)
            begin
                report($sformatf("is_alive %0b, want %0b", is_alive, want_alive));
            end
            if (live_count !== want_count)
            begin
                report($sformatf("live_count %0d, want %0d", live_count, want_count));
            end
            if (status !== want_status)
            begin
                report($sformatf("status %0d, want %0d", status, want_status));
            end
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Drop all idling once the tail of the run starts
    logic calm = 1'b0;

    int unsigned items_sent = 0;
    int unsigned stall_left = 0;

    id_pool_tracker pool = new();

    eida_req_if req_ch ();
    eida_rsp_if rsp_ch ();

    entity_id_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Request side. Hold valid across back-to-back transfers; only lower it
    // when a gap starts, so valid never sees two assignments in one step.
    // The shadow pool is updated at the edge where the transfer happens.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [REQ_W-1:0] op, input logic [ID_W-1:0] idx);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.index_in <= idx;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        pool.take_request(op, idx);
        items_sent++;
    endtask

    // Hold the request side idle until every owed response has come back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (pool.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: check each transfer, then pick ready for the next edge.
    // Stalls come in bursts of random length, counted down in stall_left.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                pool.check_result(rsp_ch.index_out, rsp_ch.is_alive,
                                  rsp_ch.live_count, rsp_ch.status);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned     pick;
        int unsigned     alloc_share;
        logic            filling;
        logic [ID_W-1:0] target;

        filling = 1'b1;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_ALLOC;
        req_ch.index_in <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pool: queries find nothing, frees hit dead ids, unused code is inert
        send_request(REQ_QUERY, 6'd0);
        send_request(REQ_QUERY, 6'd63);
        send_request(REQ_FREE, 6'd0);
        send_request(REQ_FREE, 6'd63);
        send_request(REQ_UNUSED, 6'd63);

        // Fresh allocations count up from zero
        send_request(REQ_ALLOC, 6'd63);
        send_request(REQ_ALLOC, 6'd0);
        send_request(REQ_ALLOC, 6'd21);
        send_request(REQ_QUERY, 6'd0);
        send_request(REQ_QUERY, 6'd3);
        send_request(REQ_QUERY, 6'd1);

        // Free, double free, then reuse in last-in first-out order
        send_request(REQ_FREE, 6'd1);
        send_request(REQ_FREE, 6'd1);
        send_request(REQ_QUERY, 6'd1);
        send_request(REQ_ALLOC, 6'd42);
        send_request(REQ_FREE, 6'd2);
        send_request(REQ_FREE, 6'd0);
        send_request(REQ_ALLOC, 6'd0);
        send_request(REQ_ALLOC, 6'd63);
        send_request(REQ_ALLOC, 6'd0);
        send_request(REQ_UNUSED, 6'd0);
        send_request(REQ_QUERY, 6'd42);
        hold_until_drained();

        // Random part: swing the pool between nearly empty and full, so that
        // full allocations and long free stacks both show up repeatedly.
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            if (items_sent == PAUSE_AT)
            begin
                hold_until_drained();
            end
            if (pool.live_total == POOL_SIZE && $urandom_range(0, 2) == 0)
            begin
                filling = 1'b0;
            end
            else if (pool.live_total <= 2)
            begin
                filling = 1'b1;
            end
            alloc_share = filling ? 70 : 20;
            pick = $urandom_range(0, 99);
            if (pick < alloc_share)
            begin
                send_request(REQ_ALLOC, ID_W'($urandom));
            end
            else if (pick < 80)
            begin
                send_request(REQ_FREE, pool.pick_live());
            end
            else if (pick < 93)
            begin
                // Start a query on or just past a live id, or anywhere
                case ($urandom_range(0, 2))
                    0:       target = pool.pick_live();
                    1:       target = pool.pick_live() + ID_W'(1);
                    default: target = ID_W'($urandom);
                endcase
                send_request(REQ_QUERY, target);
            end
            else if (pick < 97)
            begin
                send_request(REQ_FREE, ID_W'($urandom));
            end
            else
            begin
                send_request(REQ_UNUSED, ID_W'($urandom));
            end
        end

        // Let the last responses in, then watch a while for strays
        hold_until_drained();
        repeat (SETTLE_EDGES) @(posedge clk);
        if (pool.error_count == 0)
        begin
            $display("entity_id_allocator_unit_tb: done, clean");
        end
        else
        begin
            $display("entity_id_allocator_unit_tb: done, errors");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("entity_id_allocator_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ entity_id_allocator_unit.f @@
+incdir+rtl
rtl/eida_pkg.sv
rtl/eida_if.sv
rtl/eida_ram.sv
rtl/eida_scan.sv
rtl/entity_id_allocator_unit.sv
sim/entity_id_allocator_unit_tb.sv
